// ===== rtl/olpe_pkg.sv =====
// Shared types and constants of the ordered list with positional edits.
package olpe_pkg;

  localparam int CNT_W = 7;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_DISPLAY   = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_END   = 3'd5,
    OP_DEL_POS   = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_OOB   = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_CLAMP = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SH,
    S_INS_LAST,
    S_INS_PUT,
    S_DEL_CAP,
    S_DEL_SH,
    S_DEL_DONE,
    S_DISP_EM,
    S_RESP
  } ctrl_state_e;

  typedef enum logic [1:0] {
    VSEL_ZERO,
    VSEL_RDATA,
    VSEL_REMOVED
  } val_sel_e;

  typedef enum logic {
    WSEL_VALUE,
    WSEL_RDATA
  } wr_sel_e;

  typedef struct packed {
    op_e                     op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_beat_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] item_value;
    logic [CNT_W-1:0]        item_position;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_beat_t;

  typedef struct packed {
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic             wr_en;
    logic [CNT_W-1:0] wr_addr;
    wr_sel_e          wr_sel;
    logic             load_value;
    logic             cap_removed;
    logic             emit;
    val_sel_e         val_sel;
    status_e          emit_status;
    logic [CNT_W-1:0] emit_pos;
    logic [CNT_W-1:0] emit_count;
    logic             emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic can_emit;
  } dp_stat_t;

endpackage

// ===== rtl/olpe_datapath.sv =====
// Entry memory, operand registers and output register of the ordered list.
module olpe_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  olpe_pkg::in_beat_t  in_i,
  input  olpe_pkg::dp_cmd_t   cmd_i,
  output olpe_pkg::dp_stat_t  stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output olpe_pkg::out_beat_t out_o
);

  localparam int AW = $clog2(CAPACITY);

  logic signed [olpe_pkg::VAL_W-1:0] mem_q [CAPACITY];
  logic signed [olpe_pkg::VAL_W-1:0] rdata_q;
  logic signed [olpe_pkg::VAL_W-1:0] value_q;
  logic signed [olpe_pkg::VAL_W-1:0] removed_q;
  logic signed [olpe_pkg::VAL_W-1:0] wr_data;
  logic signed [olpe_pkg::VAL_W-1:0] emit_val;
  logic                              out_valid_q, out_valid_d;
  olpe_pkg::out_beat_t               out_q;

  always_comb begin
    unique case (cmd_i.wr_sel)
      olpe_pkg::WSEL_RDATA: wr_data = rdata_q;
      default:              wr_data = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_value) begin
      value_q <= in_i.value;
    end
    if (cmd_i.cap_removed) begin
      removed_q <= rdata_q;
    end
  end

  always_comb begin
    unique case (cmd_i.val_sel)
      olpe_pkg::VSEL_RDATA:   emit_val = rdata_q;
      olpe_pkg::VSEL_REMOVED: emit_val = removed_q;
      default:                emit_val = '0;
    endcase
  end

  assign stat_o.can_emit = !out_valid_q || !out_stall_i;
  assign out_valid_d     = cmd_i.emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status        <= cmd_i.emit_status;
      out_q.item_value    <= emit_val;
      out_q.item_position <= cmd_i.emit_pos;
      out_q.entry_count   <= cmd_i.emit_count;
      out_q.last          <= cmd_i.emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/olpe_ctrl.sv =====
// Request decoder and sequencer of the ordered list.
module olpe_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  olpe_pkg::in_beat_t in_i,
  input  olpe_pkg::dp_stat_t stat_i,
  output olpe_pkg::dp_cmd_t  cmd_o
);

  localparam int CW = olpe_pkg::CNT_W;
  localparam int PW = olpe_pkg::POS_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);
  localparam logic [PW-1:0] PONE_C = PW'(1);

  olpe_pkg::ctrl_state_e state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         ptr_q, ptr_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic                  first_q, first_d;
  olpe_pkg::status_e     res_status_q, res_status_d;
  logic [CW-1:0]         res_pos_q, res_pos_d;
  olpe_pkg::val_sel_e    res_sel_q, res_sel_d;

  logic [PW-1:0]     count_w;
  logic [CW-1:0]     ins_idx;
  olpe_pkg::status_e ins_status;
  logic [CW-1:0]     del_idx;
  logic              del_oob;
  logic              disp_last;

  assign count_w   = PW'(count_q);
  assign disp_last = (ptr_q + ONE_C) == count_q;

  // Decode the target index of the incoming request.
  always_comb begin
    ins_idx    = '0;
    ins_status = olpe_pkg::STAT_OK;
    unique case (in_i.op)
      olpe_pkg::OP_INS_FRONT: ins_idx = '0;
      olpe_pkg::OP_INS_END:   ins_idx = count_q;
      default: begin
        priority if (in_i.position <= PONE_C) begin
          ins_idx = '0;
        end else if ((in_i.position - PONE_C) <= count_w) begin
          ins_idx = CW'(in_i.position - PONE_C);
        end else begin
          ins_idx    = count_q;
          ins_status = olpe_pkg::STAT_CLAMP;
        end
      end
    endcase
  end

  always_comb begin
    del_idx = '0;
    del_oob = 1'b0;
    unique case (in_i.op)
      olpe_pkg::OP_DEL_FRONT: del_idx = '0;
      olpe_pkg::OP_DEL_END:   del_idx = count_q - ONE_C;
      default: begin
        priority if (in_i.position <= PONE_C) begin
          del_idx = '0;
        end else if (in_i.position <= count_w) begin
          del_idx = CW'(in_i.position - PONE_C);
        end else begin
          del_oob = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= olpe_pkg::S_IDLE;
      count_q      <= '0;
      ptr_q        <= '0;
      idx_q        <= '0;
      first_q      <= 1'b0;
      res_status_q <= olpe_pkg::STAT_OK;
      res_pos_q    <= '0;
      res_sel_q    <= olpe_pkg::VSEL_ZERO;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      idx_q        <= idx_d;
      first_q      <= first_d;
      res_status_q <= res_status_d;
      res_pos_q    <= res_pos_d;
      res_sel_q    <= res_sel_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    idx_d        = idx_q;
    first_d      = first_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_sel_d    = res_sel_q;

    cmd_o             = '0;
    cmd_o.wr_sel      = olpe_pkg::WSEL_VALUE;
    cmd_o.val_sel     = olpe_pkg::VSEL_ZERO;
    cmd_o.emit_status = olpe_pkg::STAT_OK;
    cmd_o.emit_count  = count_q;

    in_stall_o = (state_q != olpe_pkg::S_IDLE);

    unique case (state_q)
      olpe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          res_sel_d = olpe_pkg::VSEL_ZERO;
          unique case (in_i.op)
            olpe_pkg::OP_INS_FRONT, olpe_pkg::OP_INS_END, olpe_pkg::OP_INS_POS: begin
              if (count_q == CAP_C) begin
                res_status_d = olpe_pkg::STAT_FULL;
                res_pos_d    = '0;
                state_d      = olpe_pkg::S_RESP;
              end else begin
                cmd_o.load_value = 1'b1;
                res_status_d     = ins_status;
                res_pos_d        = ins_idx + ONE_C;
                idx_d            = ins_idx;
                if (ins_idx == count_q) begin
                  state_d = olpe_pkg::S_INS_PUT;
                end else begin
                  ptr_d   = count_q - ONE_C;
                  first_d = 1'b1;
                  state_d = olpe_pkg::S_INS_SH;
                end
              end
            end
            olpe_pkg::OP_DISPLAY: begin
              if (count_q == '0) begin
                res_status_d = olpe_pkg::STAT_EMPTY;
                res_pos_d    = '0;
                state_d      = olpe_pkg::S_RESP;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_addr = '0;
                ptr_d         = '0;
                state_d       = olpe_pkg::S_DISP_EM;
              end
            end
            olpe_pkg::OP_DEL_FRONT, olpe_pkg::OP_DEL_END, olpe_pkg::OP_DEL_POS: begin
              if (count_q == '0) begin
                res_status_d = olpe_pkg::STAT_EMPTY;
                res_pos_d    = '0;
                state_d      = olpe_pkg::S_RESP;
              end else if (del_oob) begin
                res_status_d = olpe_pkg::STAT_OOB;
                res_pos_d    = '0;
                state_d      = olpe_pkg::S_RESP;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_addr = del_idx;
                ptr_d         = del_idx + ONE_C;
                idx_d         = del_idx;
                res_status_d  = olpe_pkg::STAT_OK;
                res_pos_d     = del_idx + ONE_C;
                res_sel_d     = olpe_pkg::VSEL_REMOVED;
                state_d       = olpe_pkg::S_DEL_CAP;
              end
            end
            default: ; // unused op code: drop the beat
          endcase
        end
      end

      // Move entries up one place, highest first; each read lands two above the next read.
      olpe_pkg::S_INS_SH: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = ptr_q;
        if (!first_q) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = ptr_q + TWO_C;
          cmd_o.wr_sel  = olpe_pkg::WSEL_RDATA;
        end
        first_d = 1'b0;
        if (ptr_q == idx_q) begin
          state_d = olpe_pkg::S_INS_LAST;
        end else begin
          ptr_d = ptr_q - ONE_C;
        end
      end

      olpe_pkg::S_INS_LAST: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = idx_q + ONE_C;
        cmd_o.wr_sel  = olpe_pkg::WSEL_RDATA;
        state_d       = olpe_pkg::S_INS_PUT;
      end

      olpe_pkg::S_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = idx_q;
        cmd_o.wr_sel  = olpe_pkg::WSEL_VALUE;
        count_d       = count_q + ONE_C;
        state_d       = olpe_pkg::S_RESP;
      end

      olpe_pkg::S_DEL_CAP: begin
        cmd_o.cap_removed = 1'b1;
        if (ptr_q < count_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_q;
          ptr_d         = ptr_q + ONE_C;
          state_d       = olpe_pkg::S_DEL_SH;
        end else begin
          state_d = olpe_pkg::S_DEL_DONE;
        end
      end

      // Move entries down one place; the entry read last cycle goes one below it.
      olpe_pkg::S_DEL_SH: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = ptr_q - TWO_C;
        cmd_o.wr_sel  = olpe_pkg::WSEL_RDATA;
        if (ptr_q < count_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_q;
          ptr_d         = ptr_q + ONE_C;
        end else begin
          state_d = olpe_pkg::S_DEL_DONE;
        end
      end

      olpe_pkg::S_DEL_DONE: begin
        count_d = count_q - ONE_C;
        state_d = olpe_pkg::S_RESP;
      end

      olpe_pkg::S_DISP_EM: begin
        if (stat_i.can_emit) begin
          cmd_o.emit        = 1'b1;
          cmd_o.val_sel     = olpe_pkg::VSEL_RDATA;
          cmd_o.emit_status = olpe_pkg::STAT_OK;
          cmd_o.emit_pos    = ptr_q + ONE_C;
          cmd_o.emit_last   = disp_last;
          if (disp_last) begin
            state_d = olpe_pkg::S_IDLE;
          end else begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = ptr_q + ONE_C;
            ptr_d         = ptr_q + ONE_C;
          end
        end
      end

      olpe_pkg::S_RESP: begin
        if (stat_i.can_emit) begin
          cmd_o.emit        = 1'b1;
          cmd_o.val_sel     = res_sel_q;
          cmd_o.emit_status = res_status_q;
          cmd_o.emit_pos    = res_pos_q;
          cmd_o.emit_last   = 1'b1;
          state_d           = olpe_pkg::S_IDLE;
        end
      end

      default: state_d = olpe_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == ($past(count_q) + ONE_C)) ||
    (count_q == ($past(count_q) - ONE_C)))
    else $error("entry count moved by more than one");

  a_ins_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == olpe_pkg::S_INS_SH) |-> (ptr_q >= idx_q) && (ptr_q < count_q))
    else $error("insert shift pointer out of range");

  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.wr_en && cmd_o.rd_en) |-> (cmd_o.wr_addr != cmd_o.rd_addr))
    else $error("read and write hit the same entry");
`endif

endmodule

// ===== rtl/ordered_list_positional_edit.sv =====
// Top level of the ordered list with positional edits.
// Bounded list of up to CAPACITY signed 32-bit entries, front first, held in a
// one-read one-write memory with registered read data. A request is taken only
// while the sequencer is idle; its result goes to an output register, so the
// next request can be taken while that result still waits. Entries move one
// place per cycle through the memory port: an insert at one-based position k
// moves the entries from k onward up (none when it lands at the end), a delete
// at k moves the entries after k down, a listing gives one entry per cycle
// while the output is not stalled, and a refused or empty request goes
// straight to its response. The entries need no clearing after reset.
module ordered_list_positional_edit #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  olpe_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output olpe_pkg::out_beat_t out_o
);

  olpe_pkg::dp_cmd_t  cmd;
  olpe_pkg::dp_stat_t stat;

  olpe_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_i      (in_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  olpe_datapath #(
    .CAPACITY(CAPACITY)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

endmodule

// ===== tb/sv/tb_ordered_list_positional_edit.sv =====
// Testbench for the ordered list with positional edits: directed and random requests.
`timescale 1ns / 1ps

module tb_ordered_list_positional_edit;

  localparam int LIST_CAP   = 64;
  localparam int DRAIN_WAIT = LIST_CAP + 8;
  localparam logic [2:0] OP_UNUSED_C = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  olpe_pkg::in_beat_t  in_i        = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  olpe_pkg::out_beat_t out_o;

  // Shadow copy of the list contents and the results it owes
  logic signed [olpe_pkg::VAL_W-1:0] list_vals [LIST_CAP];
  int                                list_len = 0;
  olpe_pkg::out_beat_t               results_due [$];

  int error_count = 0;
  int beat_count  = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  int stall_left  = 0;
  int rx_draw     = 0;

  ordered_list_positional_edit #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("ordered_list_positional_edit test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    error_count++;
    $display("MISMATCH beat %0d %s: expected %h got %h", beat_count, what, want, got);
  endtask

  // Apply one request to the shadow list and queue the beats it must produce.
  function automatic void apply_list_request(input olpe_pkg::in_beat_t b);
    olpe_pkg::out_beat_t               r;
    int                                idx;
    int                                pos;
    int                                i;
    logic signed [olpe_pkg::VAL_W-1:0] removed;
    r        = '0;
    r.status = olpe_pkg::STAT_OK;
    r.last   = 1'b1;
    pos      = int'(b.position);
    idx      = 0;
    case (b.op)
      olpe_pkg::OP_INS_FRONT, olpe_pkg::OP_INS_END, olpe_pkg::OP_INS_POS: begin
        if (list_len >= LIST_CAP) begin
          r.status      = olpe_pkg::STAT_FULL;
          r.entry_count = olpe_pkg::CNT_W'(list_len);
        end else begin
          if (b.op == olpe_pkg::OP_INS_FRONT) begin
            idx = 0;
          end else if (b.op == olpe_pkg::OP_INS_END) begin
            idx = list_len;
          end else if (pos <= 1) begin
            idx = 0;
          end else if (pos - 1 <= list_len) begin
            idx = pos - 1;
          end else begin
            idx      = list_len;
            r.status = olpe_pkg::STAT_CLAMP;
          end
          for (i = list_len; i > idx; i--) list_vals[i] = list_vals[i-1];
          list_vals[idx] = b.value;
          list_len++;
          r.item_position = olpe_pkg::CNT_W'(idx + 1);
          r.entry_count   = olpe_pkg::CNT_W'(list_len);
        end
        results_due.push_back(r);
      end
      olpe_pkg::OP_DISPLAY: begin
        if (list_len == 0) begin
          r.status = olpe_pkg::STAT_EMPTY;
          results_due.push_back(r);
        end else begin
          for (i = 0; i < list_len; i++) begin
            r.item_value    = list_vals[i];
            r.item_position = olpe_pkg::CNT_W'(i + 1);
            r.entry_count   = olpe_pkg::CNT_W'(list_len);
            r.last          = (i + 1 == list_len);
            results_due.push_back(r);
          end
        end
      end
      olpe_pkg::OP_DEL_FRONT, olpe_pkg::OP_DEL_END, olpe_pkg::OP_DEL_POS: begin
        if (list_len == 0) begin
          r.status = olpe_pkg::STAT_EMPTY;
        end else if (b.op == olpe_pkg::OP_DEL_POS && pos > 1 && pos > list_len) begin
          r.status      = olpe_pkg::STAT_OOB;
          r.entry_count = olpe_pkg::CNT_W'(list_len);
        end else begin
          if (b.op == olpe_pkg::OP_DEL_FRONT || pos <= 1) idx = 0;
          if (b.op == olpe_pkg::OP_DEL_END) idx = list_len - 1;
          else if (b.op == olpe_pkg::OP_DEL_POS && pos > 1) idx = pos - 1;
          removed = list_vals[idx];
          for (i = idx; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
          r.item_value    = removed;
          r.item_position = olpe_pkg::CNT_W'(idx + 1);
          r.entry_count   = olpe_pkg::CNT_W'(list_len);
        end
        results_due.push_back(r);
      end
      default: begin
        // undefined op: no beat, no change
      end
    endcase
  endfunction

  function automatic olpe_pkg::in_beat_t make_beat(input logic [2:0] op,
                                                   input logic [31:0] v,
                                                   input logic [7:0] p);
    olpe_pkg::in_beat_t b;
    b.op       = olpe_pkg::op_e'(op);
    b.value    = v;
    b.position = p;
    return b;
  endfunction

  // Mostly positions around the current length, sometimes anywhere.
  function automatic logic [7:0] pick_position();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, list_len + 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Leave valid high on return: the next call either reuses or lowers it.
  task automatic send_request(input olpe_pkg::in_beat_t b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= b;
    do @(posedge clk_i); while (in_stall_o);
    apply_list_request(b);
  endtask

  // Hold off new requests until every owed beat has arrived.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_due.size() != 0);
  endtask

  task automatic check_result(input olpe_pkg::out_beat_t got);
    olpe_pkg::out_beat_t want;
    if (results_due.size() == 0) begin
      report_mismatch("beat with nothing due", '0, 64'(got));
      return;
    end
    want = results_due.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", 64'(want.status), 64'(got.status));
    if (got.item_value !== want.item_value)
      report_mismatch("item_value", 64'(want.item_value), 64'(got.item_value));
    if (got.item_position !== want.item_position)
      report_mismatch("item_position", 64'(want.item_position), 64'(got.item_position));
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", 64'(want.entry_count), 64'(got.entry_count));
    if (got.last !== want.last) report_mismatch("last", 64'(want.last), 64'(got.last));
  endtask

  task automatic test_empty_list();
    send_request(make_beat(olpe_pkg::OP_DISPLAY, 32'h1234_5678, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DEL_FRONT, 32'h0, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DEL_END, 32'h0, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, 32'h0, 8'd5));
    send_request(make_beat(OP_UNUSED_C, 32'hFFFF_FFFF, 8'hFF));
  endtask

  task automatic test_directed_edits();
    send_request(make_beat(olpe_pkg::OP_INS_FRONT, 32'h7FFF_FFFF, 8'd0));
    send_request(make_beat(olpe_pkg::OP_INS_END, 32'h8000_0000, 8'd0));
    send_request(make_beat(olpe_pkg::OP_INS_POS, 32'hFFFF_FFFF, 8'd0));
    send_request(make_beat(olpe_pkg::OP_INS_POS, 32'h0000_0000, 8'd1));
    // one past the end appends without clamping
    send_request(make_beat(olpe_pkg::OP_INS_POS, 32'h5555_5555, 8'd5));
    send_request(make_beat(olpe_pkg::OP_INS_POS, 32'hAAAA_AAAA, 8'd255));
    send_request(make_beat(olpe_pkg::OP_INS_POS, 32'd12345, 8'd3));
    send_request(make_beat(olpe_pkg::OP_DISPLAY, 32'h0, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, 32'h0, 8'd200));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, 32'h0, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, 32'h0, 8'd1));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, 32'h0, 8'd3));
    send_request(make_beat(olpe_pkg::OP_DEL_END, 32'h0, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DEL_FRONT, 32'h0, 8'd0));
    send_request(make_beat(olpe_pkg::OP_DISPLAY, 32'h0, 8'd0));
  endtask

  task automatic test_fill_to_capacity();
    int n;
    n = 0;
    while (list_len < LIST_CAP) begin
      // run a stretch back to back on both sides
      tx_idle_on = (n < 20 || n > 35);
      rx_idle_on = tx_idle_on;
      send_request(make_beat(3'($urandom_range(0, 2)), $urandom, pick_position()));
      n++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    wait_for_results();
    send_request(make_beat(olpe_pkg::OP_INS_FRONT, $urandom, 8'd0));
    send_request(make_beat(olpe_pkg::OP_INS_END, $urandom, 8'd0));
    send_request(make_beat(olpe_pkg::OP_INS_POS, $urandom, pick_position()));
    send_request(make_beat(olpe_pkg::OP_DISPLAY, $urandom, pick_position()));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, $urandom, 8'd64));
    send_request(make_beat(olpe_pkg::OP_DEL_POS, $urandom, 8'd65));
  endtask

  task automatic test_random_mix(input int items);
    int                 n;
    int                 roll;
    olpe_pkg::in_beat_t b;
    n = 0;
    while (n < items) begin
      if (n % 16 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45) b = make_beat(3'($urandom_range(0, 2)), $urandom, pick_position());
      else if (roll < 52) b = make_beat(olpe_pkg::OP_DISPLAY, $urandom, pick_position());
      else if (roll < 96) b = make_beat(3'($urandom_range(4, 6)), $urandom, pick_position());
      else b = make_beat(OP_UNUSED_C, $urandom, pick_position());
      send_request(b);
      if (b.op != OP_UNUSED_C) n++;
    end
  endtask

  // Receiver: draw a stall length after every accepted beat and hold stall for it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rx_draw      = rx_idle_on ? $urandom_range(0, 9) : 0;
        stall_left  <= rx_draw;
        out_stall_i <= (rx_draw != 0);
      end else if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= (stall_left > 1);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result(out_o);
      beat_count++;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_directed_edits();
    test_fill_to_capacity();
    test_random_mix(22);
    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch("beats still due", '0, 64'(results_due.size()));
    if (error_count == 0) begin
      $display("ordered_list_positional_edit test passed");
    end else begin
      $display("ordered_list_positional_edit test failed");
    end
    $finish;
  end

endmodule
